### rtl/bmrs_pkg.sv
package bmrs_pkg;

  // default geometry of the bit store
  localparam int MAX_BITS_DEF  = 4096;
  localparam int WORD_BITS_DEF = 32;

  // fixed field widths
  localparam int MODE_W  = 2;
  localparam int START_W = 12;
  localparam int END_W   = 13;
  localparam int SIZE_W  = 13;

  // bits_in_use after reset
  localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;

  // request codes
  typedef enum logic [MODE_W-1:0] {
    MODE_SET = 2'd0,
    MODE_ANY = 2'd1,
    MODE_ALL = 2'd2
  } mode_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR  = 3'd0,
    ST_IDLE   = 3'd1,
    ST_RUN    = 3'd2,
    ST_REPORT = 3'd3
  } state_t;

endpackage

### rtl/bmrs_ram.sv
module bmrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/bitmap_range_set_test.sv
// Range bit store: sets, tests for any set, or tests for all set over the
// half-open bit range [range_start, range_end). A transaction is taken at a
// clock edge with start high and busy low; its result appears on answer and
// range_error for exactly one cycle with done high, and must be captured
// then, since there is no way to hold it off. After reset the block clears
// its word memory, one word a cycle, with busy high until the last word is
// cleared; bits_in_use may be written during that time. A valid request
// walks the memory from word 0 through the word holding bit range_end-1,
// one word a cycle through the one memory, reading each word and, for a
// set, writing it back with the range bits set. Once the last word has been
// tested its result is out with done high, busy falls in the cycle after
// that, and the next transaction can be taken once the block is idle. A
// rejected request, or the unused mode 3, reports in the cycle right after
// acceptance and allows the next transaction once busy has fallen. The user
// must write bits_in_use only while the block is idle; the block itself
// does not enforce this.
module bitmap_range_set_test
  import bmrs_pkg::*;
#(
  parameter int MAX_BITS  = MAX_BITS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               bits_in_use_we,
  input  logic [SIZE_W-1:0]  bits_in_use,
  // request
  input  logic               start,
  output logic               busy,
  input  logic [MODE_W-1:0]  mode,
  input  logic [START_W-1:0] range_start,
  input  logic [END_W-1:0]   range_end,
  // result
  output logic               done,
  output logic               answer,
  output logic               range_error
);

  localparam int DEPTH = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SPAN  = $clog2(DEPTH * WORD_BITS + 1);
  localparam int PW    = (SPAN > END_W) ? SPAN : END_W;
  localparam int LIMW  = ($clog2(MAX_BITS + 1) > SIZE_W) ? $clog2(MAX_BITS + 1) : SIZE_W;

  localparam logic [LIMW-1:0] MAX_LIM   = LIMW'(MAX_BITS);
  localparam logic [PW-1:0]   WORD_STEP = PW'(WORD_BITS);
  localparam logic [AW-1:0]   LAST_IDX  = AW'(DEPTH - 1);

  state_t state, state_next;

  // configuration register
  logic [SIZE_W-1:0] size_in_use;

  // latched request
  logic [MODE_W-1:0]  mode_q;
  logic [START_W-1:0] start_q;
  logic [END_W-1:0]   end_q;
  logic               err_q;
  logic               acc;

  // walk counters and the word in flight
  logic [AW-1:0] rd_idx;
  logic [PW-1:0] rd_base;
  logic          pend;
  logic [AW-1:0] pend_idx;
  logic [PW-1:0] pend_base;

  // memory port
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;

  logic                 accept;
  logic                 in_err;
  logic                 issue;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] hits;
  logic                 any_hit;
  logic                 all_hit;
  logic [LIMW-1:0]      limit;
  logic [PW-1:0]        start_ext;
  logic [PW-1:0]        end_ext;

  bmrs_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  // range check of the incoming request
  always_comb begin
    limit  = (LIMW'(size_in_use) > MAX_LIM) ? MAX_LIM : LIMW'(size_in_use);
    in_err = (END_W'(range_start) >= range_end) || (LIMW'(range_end) > limit);
  end

  assign accept = start && (state == ST_IDLE);
  assign issue  = (state == ST_RUN) && (rd_base < end_ext);

  // bits of the word in flight that fall inside the range
  assign start_ext = PW'(start_q);
  assign end_ext   = PW'(end_q);

  always_comb begin
    logic [PW-1:0] pos;
    pos = '0;
    for (int k = 0; k < WORD_BITS; k++) begin
      pos     = pend_base + PW'(k);
      mask[k] = (pos >= start_ext) && (pos < end_ext);
    end
  end

  assign hits    = ram_rdata & mask;
  assign any_hit = |hits;
  assign all_hit = (hits == mask);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (rd_idx == LAST_IDX) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (in_err || (mode != MODE_SET && mode != MODE_ANY && mode != MODE_ALL)) begin
            state_next = ST_REPORT;
          end else begin
            state_next = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (!issue && !pend) begin
          state_next = ST_REPORT;
        end
      end
      ST_REPORT: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs and memory writes
  always_comb begin
    busy      = 1'b1;
    done      = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = pend_idx;
    ram_wdata = ram_rdata | mask;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = rd_idx;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_RUN: begin
        ram_we = pend && (mode_q == MODE_SET);
      end
      ST_REPORT: begin
        done = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  assign answer      = acc;
  assign range_error = err_q;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      rd_idx      <= '0;
      pend        <= 1'b0;
      size_in_use <= SIZE_RESET;
    end else begin
      state <= state_next;
      pend  <= issue;
      if (bits_in_use_we) begin
        size_in_use <= bits_in_use;
      end
      if (state == ST_CLEAR || issue) begin
        rd_idx <= rd_idx + AW'(1);
      end else if (accept) begin
        rd_idx <= '0;
      end
    end
  end

  // request latch, walk position and accumulated test result
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q  <= mode;
      start_q <= range_start;
      end_q   <= range_end;
      err_q   <= in_err;
      acc     <= !in_err && (mode == MODE_ALL);
      rd_base <= '0;
    end else if (state == ST_RUN) begin
      if (issue) begin
        rd_base <= rd_base + WORD_STEP;
      end
      pend_idx  <= rd_idx;
      pend_base <= rd_base;
      if (pend && mode_q == MODE_ANY) begin
        acc <= acc | any_hit;
      end else if (pend && mode_q == MODE_ALL) begin
        acc <= acc & all_hit;
      end
    end
  end

endmodule

### sim/bitmap_range_set_test_tb.sv
module bitmap_range_set_test_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bmrs_pkg::*;

  // the fourth request code has no name in the package
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int STORE_WORDS = MAX_BITS_DEF / WORD_BITS_DEF;
  localparam int PHASES = 8;

  typedef struct packed {
    logic answer;
    logic range_error;
  } range_result_t;

  typedef struct packed {
    logic [MODE_W-1:0]  op;
    logic [START_W-1:0] lo;
    logic [END_W-1:0]   hi;
    logic               typed;
    logic               ans;
    logic               err;
  } range_vector_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               size_we;
  logic [SIZE_W-1:0]  size_cfg;
  logic               start;
  logic               busy;
  logic [MODE_W-1:0]  mode;
  logic [START_W-1:0] range_start;
  logic [END_W-1:0]   range_end;
  logic               done;
  logic               answer;
  logic               range_error;

  // mirror of the bit store and of bits_in_use
  logic [WORD_BITS_DEF-1:0] shadow_words [STORE_WORDS];
  logic [SIZE_W-1:0]        shadow_size;

  range_result_t results_due [$];
  range_vector_t directed_plan [$];
  range_result_t arrived_want;

  int fails;
  int n_sent;
  int n_results;
  int n_sets;
  int n_rejected;
  int n_true;
  int burst_left;
  int last_lo;
  int last_hi;

  bitmap_range_set_test dut (
    .clk           (clk),
    .rst           (rst),
    .bits_in_use_we(size_we),
    .bits_in_use   (size_cfg),
    .start         (start),
    .busy          (busy),
    .mode          (mode),
    .range_start   (range_start),
    .range_end     (range_end),
    .done          (done),
    .answer        (answer),
    .range_error   (range_error)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // expected result of one request, updating the mirrored store
  function automatic range_result_t predict_range_result(logic [MODE_W-1:0] op,
                                                         logic [START_W-1:0] lo,
                                                         logic [END_W-1:0] hi);
    range_result_t r;
    int lim;
    int i;
    r = '0;
    lim = (shadow_size > MAX_BITS_DEF) ? MAX_BITS_DEF : int'(shadow_size);
    if (int'(lo) >= int'(hi) || int'(hi) > lim) begin
      r.range_error = 1'b1;
    end else if (op == MODE_SET) begin
      for (i = lo; i < hi; i++)
        shadow_words[i / WORD_BITS_DEF][i % WORD_BITS_DEF] = 1'b1;
    end else if (op == MODE_ANY) begin
      for (i = lo; i < hi; i++)
        if (shadow_words[i / WORD_BITS_DEF][i % WORD_BITS_DEF]) r.answer = 1'b1;
    end else if (op == MODE_ALL) begin
      r.answer = 1'b1;
      for (i = lo; i < hi; i++)
        if (!shadow_words[i / WORD_BITS_DEF][i % WORD_BITS_DEF]) r.answer = 1'b0;
    end
    return r;
  endfunction

  function automatic void add_vector(logic [MODE_W-1:0] op, int lo, int hi,
                                     logic typed, logic ans, logic err);
    range_vector_t v;
    v.op = op;
    v.lo = lo[START_W-1:0];
    v.hi = hi[END_W-1:0];
    v.typed = typed;
    v.ans = ans;
    v.err = err;
    directed_plan.push_back(v);
  endfunction

  // present one transaction and hold it until the block takes it
  task automatic send_request(logic [MODE_W-1:0] op, logic [START_W-1:0] lo,
                              logic [END_W-1:0] hi, logic typed, logic ans, logic err);
    range_result_t want;
    start <= 1'b1;
    mode <= op;
    range_start <= lo;
    range_end <= hi;
    do @(posedge clk); while (busy);
    want = predict_range_result(op, lo, hi);
    if (typed) want = '{ans, err};
    results_due.push_back(want);
    n_sent++;
    if (want.range_error) n_rejected++;
    else if (op == MODE_SET) n_sets++;
    if (want.answer) n_true++;
  endtask

  // wait until the block is idle with nothing outstanding
  task automatic wait_drained();
    do @(negedge clk); while (results_due.size() != 0 || busy);
    @(posedge clk);
  endtask

  task automatic write_size(logic [SIZE_W-1:0] value);
    start <= 1'b0;
    wait_drained();
    size_we <= 1'b1;
    size_cfg <= value;
    @(posedge clk);
    size_we <= 1'b0;
    shadow_size = value;
  endtask

  // sender bursts, gaps and occasional full drains
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      if ($urandom_range(0, 19) == 0) begin
        start <= 1'b0;
        wait_drained();
      end else begin
        gap = $urandom_range(0, 12);
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  // mostly well-formed ranges near a hot window, some noise
  task automatic pick_request(int lim, int win_base, int win_len,
                              output logic [MODE_W-1:0] op,
                              output logic [START_W-1:0] lo,
                              output logic [END_W-1:0] hi);
    int r;
    int s;
    int e;
    int len;
    r = $urandom_range(0, 99);
    if (lim == 0 || r < 12) begin
      op = MODE_W'($urandom_range(0, 3));
      s = $urandom_range(0, 4095);
      if (r < 4) e = lim + $urandom_range(0, 1);
      else e = $urandom_range(0, 8191);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 35) op = MODE_SET;
      else if (r < 65) op = MODE_ANY;
      else if (r < 95) op = MODE_ALL;
      else op = MODE_UNUSED;
      if (op == MODE_SET) begin
        s = win_base + $urandom_range(0, win_len - 1);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 4);
        e = s + len;
      end else if ($urandom_range(0, 2) == 0) begin
        // probe inside the most recent set range
        s = $urandom_range(last_lo, last_hi - 1);
        e = $urandom_range(s + 1, last_hi);
      end else begin
        s = win_base + $urandom_range(0, win_len - 1);
        e = s + $urandom_range(1, 32);
      end
      if (e > lim) e = lim;
      if (s >= e) s = e - 1;
      if (op == MODE_SET) begin
        last_lo = s;
        last_hi = e;
      end
    end
    lo = s[START_W-1:0];
    hi = e[END_W-1:0];
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      if (results_due.size() == 0) begin
        $error("result with none outstanding: answer %0b range_error %0b",
               answer, range_error);
        fails++;
      end else begin
        arrived_want = results_due.pop_front();
        n_results++;
        if (answer !== arrived_want.answer) begin
          $error("answer mismatch: expected %0b, got %0b", arrived_want.answer, answer);
          fails++;
        end
        if (range_error !== arrived_want.range_error) begin
          $error("range_error mismatch: expected %0b, got %0b",
                 arrived_want.range_error, range_error);
          fails++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // stimulus
  initial begin
    logic [SIZE_W-1:0]  sizes [PHASES];
    int                 counts [PHASES];
    logic [MODE_W-1:0]  op;
    logic [START_W-1:0] lo;
    logic [END_W-1:0]   hi;
    int                 lim;
    int                 win_base;
    int                 win_len;

    rst <= 1'b1;
    size_we <= 1'b0;
    size_cfg <= '0;
    start <= 1'b0;
    mode <= MODE_SET;
    range_start <= '0;
    range_end <= '0;
    fails = 0;
    n_sent = 0;
    n_results = 0;
    n_sets = 0;
    n_rejected = 0;
    n_true = 0;
    burst_left = 0;
    foreach (shadow_words[i]) shadow_words[i] = '0;
    shadow_size = SIZE_RESET;

    // empty store, reset size
    add_vector(MODE_ANY, 0, 4096, 1, 0, 0);
    add_vector(MODE_ALL, 0, 1, 1, 0, 0);
    add_vector(MODE_ALL, 4095, 4096, 1, 0, 0);
    // first and last bit
    add_vector(MODE_SET, 0, 1, 1, 0, 0);
    add_vector(MODE_SET, 4095, 4096, 1, 0, 0);
    add_vector(MODE_ANY, 0, 4096, 1, 1, 0);
    add_vector(MODE_ALL, 4095, 4096, 1, 1, 0);
    add_vector(MODE_ALL, 0, 4096, 1, 0, 0);
    // word boundary and whole words
    add_vector(MODE_SET, 31, 33, 0, 0, 0);
    add_vector(MODE_ALL, 31, 33, 0, 0, 0);
    add_vector(MODE_ANY, 1, 31, 0, 0, 0);
    add_vector(MODE_ALL, 30, 34, 0, 0, 0);
    add_vector(MODE_SET, 64, 128, 0, 0, 0);
    add_vector(MODE_ALL, 64, 128, 0, 0, 0);
    add_vector(MODE_ANY, 128, 4096, 0, 0, 0);
    add_vector(MODE_SET, 100, 101, 0, 0, 0);
    add_vector(MODE_ANY, 2048, 4095, 0, 0, 0);
    // invalid ranges
    add_vector(MODE_SET, 5, 5, 1, 0, 1);
    add_vector(MODE_ANY, 9, 3, 1, 0, 1);
    add_vector(MODE_ALL, 0, 4097, 1, 0, 1);
    add_vector(MODE_SET, 4095, 8191, 1, 0, 1);
    add_vector(MODE_ANY, 0, 0, 1, 0, 1);
    // unused code, valid and invalid range
    add_vector(MODE_UNUSED, 0, 8, 1, 0, 0);
    add_vector(MODE_UNUSED, 7, 7, 1, 0, 1);
    add_vector(MODE_ALL, 4095, 4096, 1, 1, 0);

    sizes[0] = 13'd8191; counts[0] = 200;
    sizes[1] = 13'd1;    counts[1] = 60;
    sizes[2] = 13'd0;    counts[2] = 40;
    sizes[3] = SIZE_W'($urandom_range(1, 4096)); counts[3] = 200;
    sizes[4] = 13'd33;   counts[4] = 150;
    sizes[5] = SIZE_W'($urandom_range(1, 4096)); counts[5] = 200;
    sizes[6] = SIZE_W'($urandom_range(2048, 4095)); counts[6] = 180;
    sizes[7] = 13'd4096; counts[7] = 200;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_plan[i]) begin
      send_request(directed_plan[i].op, directed_plan[i].lo, directed_plan[i].hi,
                   directed_plan[i].typed, directed_plan[i].ans, directed_plan[i].err);
      pace();
    end

    // random phases, one size setting each
    for (int p = 0; p < PHASES; p++) begin
      write_size(sizes[p]);
      lim = (sizes[p] > MAX_BITS_DEF) ? MAX_BITS_DEF : int'(sizes[p]);
      win_len = (lim == 0) ? 1 : ((lim < 512) ? lim : 512);
      win_base = (lim == 0) ? 0 : $urandom_range(0, lim - win_len);
      last_lo = win_base;
      last_hi = win_base + 1;
      for (int n = 0; n < counts[p]; n++) begin
        pick_request(lim, win_base, win_len, op, lo, hi);
        send_request(op, lo, hi, 0, 0, 0);
        pace();
      end
    end

    // fill the whole store, then every bit reads back set
    send_request(MODE_SET, 12'd0, 13'd4096, 1, 0, 0);
    send_request(MODE_ALL, 12'd0, 13'd4096, 1, 1, 0);

    start <= 1'b0;
    wait_drained();
    repeat (140) @(posedge clk);
    if (results_due.size() != 0) begin
      $error("%0d results never arrived", results_due.size());
      fails++;
    end

    $display("covered %0d requests over %0d size settings: %0d valid sets, %0d rejected,",
             n_sent, PHASES + 1, n_sets, n_rejected);
    $display("%0d tests answered true, %0d results checked", n_true, n_results);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
